// File: src/sensor_frame_deframer_unit_macros.svh
// assertion macros for the sensor frame deframer
// used by sensor_frame_deframer_unit, expects clk_i and rst_ni in scope
`ifndef SENSOR_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sensor frame deframer check failed");

// next-cycle implication, checked out of reset
`define SFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sensor frame deframer check failed");

`endif

// File: src/sfd_pkg.sv
// shared constants and types for the sensor frame deframer
// no dependencies
`default_nettype none

package sfd_pkg;

  localparam int OBJECT_SLOTS = 3;
  localparam int SLOT_BYTES   = 8;
  localparam int HDR_BYTES    = 4;
  localparam int TAIL_BYTES   = 2;
  localparam int WINDOW_LEN   = HDR_BYTES + SLOT_BYTES * OBJECT_SLOTS + TAIL_BYTES;
  localparam int CNT_W        = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W       = 3;
  localparam int WORD_W       = 8 * SLOT_BYTES;
  localparam int TIME_W       = 32;

  localparam logic [7:0] HDR_B0  = 8'hAA;
  localparam logic [7:0] HDR_B1  = 8'hFF;
  localparam logic [7:0] HDR_B2  = 8'h03;
  localparam logic [7:0] HDR_B3  = 8'h00;
  localparam logic [7:0] TAIL_B0 = 8'h55;
  localparam logic [7:0] TAIL_B1 = 8'hCC;

  typedef logic [7:0]        octet_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TIME_W-1:0] stamp_t;

endpackage

`default_nettype wire

// File: src/sensor_frame_deframer_unit.sv
// sensor frame deframer: finds header/tail framed sensor records in a byte stream
// depends on sfd_pkg and sensor_frame_deframer_unit_macros.svh
//
// One byte request is taken per clock while in_stall_o is low. Each byte
// shifts into a window of the last WINDOW_LEN bytes; when at least WINDOW_LEN
// bytes have arrived since the previous frame and the window opens with
// AA FF 03 00 and closes with 55 CC, the payload is copied into a frame buffer
// in the same cycle. From the next cycle the buffer presents one 64-bit object
// word per clock while the output does not stall, slot 0 first, with the frame
// timestamp and a last flag on the final slot. The byte side stalls only while
// buffered words are still unread and the next byte could close another frame;
// with frames WINDOW_LEN bytes apart and no output stall, the sustained rate is
// one byte per cycle.
`default_nettype none

`include "sensor_frame_deframer_unit_macros.svh"

module sensor_frame_deframer_unit (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [7:0]             rx_byte_i,
  input  wire  [31:0]            now_ms_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [63:0]            object_word_o,
  output logic [2:0]             slot_index_o,
  output logic [31:0]            frame_time_ms_o,
  output logic                   last_slot_o
);
  import sfd_pkg::*;

  localparam logic [CNT_W-1:0]  FRAME_CNT = CNT_W'(WINDOW_LEN);
  localparam logic [CNT_W-1:0]  NEAR_CNT  = CNT_W'(WINDOW_LEN - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(OBJECT_SLOTS - 1);

  octet_t             win_q [WINDOW_LEN];
  octet_t             win_d [WINDOW_LEN];
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
  word_t              buf_q [OBJECT_SLOTS];
  word_t              buf_d [OBJECT_SLOTS];
  stamp_t             time_q;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               busy_q, busy_d;
  logic               in_acc, out_acc, match, frame_hit;

  assign in_stall_o = busy_q && (cnt_q >= NEAR_CNT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  // window after shifting in the new byte
  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW_LEN-1] = rx_byte_i;
  end

  assign cnt_inc = (cnt_q < FRAME_CNT) ? cnt_q + CNT_W'(1) : cnt_q;

  assign match = (cnt_inc == FRAME_CNT) &&
                 (win_d[0] == HDR_B0) && (win_d[1] == HDR_B1) &&
                 (win_d[2] == HDR_B2) && (win_d[3] == HDR_B3) &&
                 (win_d[WINDOW_LEN-2] == TAIL_B0) &&
                 (win_d[WINDOW_LEN-1] == TAIL_B1);

  assign frame_hit = in_acc && match;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = frame_hit ? '0 : cnt_inc;
    end
  end

  // frame buffer: load on a hit, shift down one word per output request
  always_comb begin
    for (int s = 0; s < OBJECT_SLOTS; s++) begin
      buf_d[s] = buf_q[s];
    end
    if (frame_hit) begin
      for (int s = 0; s < OBJECT_SLOTS; s++) begin
        for (int k = 0; k < SLOT_BYTES; k++) begin
          buf_d[s][8*k +: 8] = win_d[HDR_BYTES + s*SLOT_BYTES + k];
        end
      end
    end else if (out_acc) begin
      for (int s = 0; s < OBJECT_SLOTS - 1; s++) begin
        buf_d[s] = buf_q[s+1];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    priority if (frame_hit) begin
      busy_d = 1'b1;
      slot_d = '0;
    end else if (out_acc) begin
      if (slot_q == LAST_SLOT) begin
        busy_d = 1'b0;
        slot_d = '0;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      slot_q <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      slot_q <= slot_d;
      if (in_acc) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_q[i] <= win_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < OBJECT_SLOTS; s++) begin
      buf_q[s] <= buf_d[s];
    end
    if (frame_hit) begin
      time_q <= now_ms_i;
    end
  end

  assign out_valid_o     = busy_q;
  assign object_word_o   = buf_q[0];
  assign slot_index_o    = slot_q;
  assign frame_time_ms_o = time_q;
  assign last_slot_o     = (slot_q == LAST_SLOT);

  // a new frame never lands on unread words
  `SFD_ASSERT_NOW(a_hit_when_free, frame_hit, !busy_q)
  // a hit starts a fresh drain at slot zero and restarts the byte count
  `SFD_ASSERT_NEXT(a_hit_starts, frame_hit, out_valid_o && slot_q == '0 && cnt_q == '0)
  // the last word ends the drain
  `SFD_ASSERT_NEXT(a_last_ends, out_acc && last_slot_o, !out_valid_o)
  // slot number stays within the frame
  `SFD_ASSERT_NOW(a_slot_range, out_valid_o, slot_q <= LAST_SLOT)

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for sensor_frame_deframer_unit: byte stream in, object words out
// depends on sfd_pkg; predicts every object word and checks it field by field
`default_nettype none

module tb;
  import sfd_pkg::*;

  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * OBJECT_SLOTS + 10;

  typedef octet_t frame_t [WINDOW_LEN];

  typedef struct {
    word_t      word;
    logic [2:0] slot;
    stamp_t     stamp;
    logic       last;
  } slot_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  octet_t     rx_byte = '0;
  stamp_t     now_ms = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  word_t      object_word;
  logic [2:0] slot_index;
  stamp_t     frame_time_ms;
  logic       last_slot;

  octet_t       rx_window [WINDOW_LEN];
  int           bytes_since = 0;
  slot_result_t pending_words [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           quiet_cycles = 0;
  bit           send_gaps = 1'b1;
  logic         recv_stalls = 1'b1;
  logic         hold_toggle = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;
  int           stall_left = 0;

  sensor_frame_deframer_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .object_word_o   (object_word),
    .slot_index_o    (slot_index),
    .frame_time_ms_o (frame_time_ms),
    .last_slot_o     (last_slot)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic track_byte(input octet_t b, input stamp_t t);
    slot_result_t r;
    int i;
    int s;
    int k;
    for (i = 0; i < WINDOW_LEN - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[WINDOW_LEN - 1] = b;
    if (bytes_since < WINDOW_LEN) bytes_since++;
    if (bytes_since == WINDOW_LEN &&
        rx_window[0] == HDR_B0 && rx_window[1] == HDR_B1 &&
        rx_window[2] == HDR_B2 && rx_window[3] == HDR_B3 &&
        rx_window[WINDOW_LEN - 2] == TAIL_B0 &&
        rx_window[WINDOW_LEN - 1] == TAIL_B1) begin
      for (s = 0; s < OBJECT_SLOTS; s++) begin
        for (k = 0; k < SLOT_BYTES; k++) begin
          r.word[8*k +: 8] = rx_window[HDR_BYTES + s * SLOT_BYTES + k];
        end
        r.slot  = 3'(s);
        r.stamp = t;
        r.last  = (s == OBJECT_SLOTS - 1);
        pending_words.push_back(r);
      end
      bytes_since = 0;
    end
  endtask

  task automatic send_byte(input octet_t b, input stamp_t t);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    now_ms   <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_byte(b, t);
    items_sent++;
  endtask

  // the last byte sent carries the given stamp
  task automatic send_bytes(input frame_t f, input int count, input stamp_t stamp);
    int i;
    for (i = 0; i < count; i++) begin
      send_byte(f[i], (i == count - 1) ? stamp : stamp_t'($urandom()));
    end
  endtask

  function automatic frame_t make_frame();
    frame_t f;
    int i;
    for (i = 0; i < WINDOW_LEN; i++) f[i] = octet_t'($urandom_range(0, 255));
    f[0] = HDR_B0;
    f[1] = HDR_B1;
    f[2] = HDR_B2;
    f[3] = HDR_B3;
    f[WINDOW_LEN - 2] = TAIL_B0;
    f[WINDOW_LEN - 1] = TAIL_B1;
    return f;
  endfunction

  task automatic test_reset_window();
    send_byte(HDR_B0, $urandom());
    send_byte(HDR_B1, $urandom());
    send_byte(HDR_B2, $urandom());
    send_byte(HDR_B3, $urandom());
    send_byte(TAIL_B0, $urandom());
    send_byte(TAIL_B1, $urandom());
  endtask

  task automatic test_extreme_payload();
    frame_t f;
    int k;
    f = make_frame();
    for (k = 0; k < SLOT_BYTES; k++) begin
      f[HDR_BYTES + k]                  = 8'h00;
      f[HDR_BYTES + SLOT_BYTES + k]     = 8'hFF;
      f[HDR_BYTES + 2 * SLOT_BYTES + k] = k[0] ? 8'h7F : 8'h80;
    end
    // header copy inside slot 0 for the spacing test that follows
    f[HDR_BYTES]     = HDR_B0;
    f[HDR_BYTES + 1] = HDR_B1;
    f[HDR_BYTES + 2] = HDR_B2;
    f[HDR_BYTES + 3] = HDR_B3;
    send_bytes(f, WINDOW_LEN, 32'hFFFF_FFFF);
  endtask

  // window now opens with the header copy, but too few bytes since the frame
  task automatic test_frame_spacing();
    send_byte(8'h12, $urandom());
    send_byte(8'h34, $urandom());
    send_byte(TAIL_B0, $urandom());
    send_byte(TAIL_B1, $urandom());
  endtask

  task automatic test_count_saturation();
    int i;
    for (i = 0; i < 40; i++) send_byte(octet_t'($urandom_range(0, 255)), $urandom());
    send_bytes(make_frame(), WINDOW_LEN, $urandom());
  endtask

  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    hold_toggle <= ~hold_toggle;
    send_bytes(make_frame(), WINDOW_LEN, 32'h0000_0000);
    send_bytes(make_frame(), WINDOW_LEN, $urandom());
    send_bytes(make_frame(), WINDOW_LEN, $urandom());
    send_gaps = 1'b1;
  endtask

  task automatic test_random_stream();
    frame_t f;
    int pick;
    int pos;
    int i;
    while (items_sent < 380) begin
      f = make_frame();
      pick = $urandom_range(0, 9);
      case (pick)
        6: begin
          pos = $urandom_range(0, 5);
          if (pos > 3) pos = WINDOW_LEN - 6 + pos;
          f[pos] = f[pos] ^ octet_t'($urandom_range(1, 255));
          send_bytes(f, WINDOW_LEN, $urandom());
        end
        7: begin
          for (i = $urandom_range(1, 40); i > 0; i--) begin
            send_byte(octet_t'($urandom_range(0, 255)), $urandom());
          end
        end
        8: begin
          send_bytes(f, $urandom_range(5, WINDOW_LEN - 1), $urandom());
        end
        9: begin
          pos = $urandom_range(HDR_BYTES, WINDOW_LEN - 6);
          f[pos]     = HDR_B0;
          f[pos + 1] = HDR_B1;
          f[pos + 2] = HDR_B2;
          f[pos + 3] = HDR_B3;
          send_bytes(f, WINDOW_LEN, $urandom());
          for (i = 0; i < pos - 2; i++) send_byte(octet_t'($urandom_range(0, 255)), $urandom());
          send_byte(TAIL_B0, $urandom());
          send_byte(TAIL_B1, $urandom());
        end
        default: begin
          send_bytes(f, WINDOW_LEN, $urandom());
        end
      endcase
    end
  endtask

  task automatic test_full_rate();
    int i;
    send_gaps = 1'b0;
    recv_stalls <= 1'b0;
    send_bytes(make_frame(), WINDOW_LEN, $urandom());
    send_bytes(make_frame(), WINDOW_LEN, $urandom());
    for (i = 0; i < 10; i++) send_byte(octet_t'($urandom_range(0, 255)), $urandom());
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected object word %h slot %0d", object_word, slot_index);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (object_word !== want.word) begin
          $error("object_word: expected %h, got %h", want.word, object_word);
          mismatches++;
        end
        if (slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, slot_index);
          mismatches++;
        end
        if (frame_time_ms !== want.stamp) begin
          $error("frame_time_ms: expected %h, got %h", want.stamp, frame_time_ms);
          mismatches++;
        end
        if (last_slot !== want.last) begin
          $error("last_slot: expected %b, got %b", want.last, last_slot);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (rx_window[i]) rx_window[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_extreme_payload();
    test_frame_spacing();
    test_count_saturation();
    test_output_backpressure();
    test_random_stream();
    test_full_rate();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
